// File: sv/crcfr_pkg.sv
`default_nettype none

package crcfr_pkg;

  // frame limits
  localparam int MAX_PAYLOAD_BYTES = 64;
  localparam int IDX_W             = $clog2(MAX_PAYLOAD_BYTES);
  localparam int CNT_W             = $clog2(MAX_PAYLOAD_BYTES + 1);
  localparam int NUM_BANKS         = 2;
  localparam int BANK_W            = $clog2(NUM_BANKS);
  localparam int RAM_DEPTH         = NUM_BANKS * MAX_PAYLOAD_BYTES;
  localparam int RAM_AW            = $clog2(RAM_DEPTH);

  localparam logic [7:0] START_RESET = 8'hAA;
  localparam logic [7:0] MAX_LEN     = 8'(MAX_PAYLOAD_BYTES + 1);
  localparam logic [7:0] CRC_POLY    = 8'h07;
  localparam logic [7:0] CRC_INIT    = 8'h00;

  // result status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_CRC_ERR = 1'b1;

  // front state machine
  typedef enum logic [3:0] {
    FR_HUNT = 4'b0001,
    FR_LEN  = 4'b0010,
    FR_BODY = 4'b0100,
    FR_CRC  = 4'b1000
  } front_state_t;

  // back state machine
  typedef enum logic [3:0] {
    BK_IDLE = 4'b0001,
    BK_ONE  = 4'b0010,
    BK_RD   = 4'b0100,
    BK_LD   = 4'b1000
  } back_state_t;

  // one finished frame, handed from front to back
  typedef struct packed {
    logic              status;
    logic [7:0]        signal_id;
    logic [CNT_W-1:0]  count;
    logic [BANK_W-1:0] bank;
  } cmd_t;

  // back tells front that a buffer bank is free again
  typedef struct packed {
    logic              valid;
    logic [BANK_W-1:0] bank;
  } rel_t;

  // crc-8, msb first, one byte
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: sv/crcfr_ram.sv
`default_nettype none

module crcfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/crcfr_front.sv
`default_nettype none

module crcfr_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [7:0]                           cfg_wdata,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [7:0]                           s_tdata,
  output logic                                      ram_we,
  output logic      [crcfr_pkg::RAM_AW-1:0]         ram_waddr,
  output logic      [7:0]                           ram_wdata,
  output logic                                      push,
  output crcfr_pkg::cmd_t                           push_cmd,
  input  crcfr_pkg::rel_t                           rel,
  output logic      [crcfr_pkg::NUM_BANKS-1:0]      busy
);
  import crcfr_pkg::*;

  front_state_t      state, state_next;
  logic [7:0]        start_byte;
  logic [CNT_W-1:0]  frame_length, frame_length_next;
  logic [CNT_W-1:0]  fill_count, fill_count_next;
  logic [7:0]        running_crc, running_crc_next;
  logic [7:0]        signal_id, signal_id_next;
  logic [BANK_W-1:0] wr_bank, wr_bank_next;
  logic [NUM_BANKS-1:0] busy_next;
  logic              accept;
  logic [IDX_W-1:0]  wr_idx;

  // stall only when the bank to be filled is still being drained
  assign s_tready = !((state == FR_BODY) && busy[wr_bank]);
  assign accept   = s_tvalid && s_tready;

  assign wr_idx    = IDX_W'(fill_count - CNT_W'(1));
  assign ram_waddr = {wr_bank, wr_idx};
  assign ram_wdata = s_tdata;
  assign ram_we    = accept && (state == FR_BODY) && (fill_count != '0);

  assign push              = accept && (state == FR_CRC);
  assign push_cmd.status   = (s_tdata != running_crc) ? STATUS_CRC_ERR : STATUS_OK;
  assign push_cmd.signal_id = signal_id;
  assign push_cmd.count    = fill_count - CNT_W'(1);
  assign push_cmd.bank     = wr_bank;

  // start byte register
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_RESET;
    end else if (cfg_we) begin
      start_byte <= cfg_wdata;
    end
  end

  // deframing state machine
  always_comb begin
    state_next        = state;
    frame_length_next = frame_length;
    fill_count_next   = fill_count;
    running_crc_next  = running_crc;
    signal_id_next    = signal_id;
    wr_bank_next      = wr_bank;
    if (accept) begin
      unique case (state)
        FR_HUNT: begin
          if (s_tdata == start_byte) begin
            fill_count_next = '0;
            state_next      = FR_LEN;
          end
        end
        FR_LEN: begin
          if ((s_tdata == 8'd0) || (s_tdata > MAX_LEN)) begin
            state_next = FR_HUNT;
          end else begin
            frame_length_next = CNT_W'(s_tdata);
            fill_count_next   = '0;
            running_crc_next  = CRC_INIT;
            state_next        = FR_BODY;
          end
        end
        FR_BODY: begin
          if (fill_count == '0) begin
            signal_id_next = s_tdata;
          end
          fill_count_next  = fill_count + CNT_W'(1);
          running_crc_next = crc8_update(running_crc, s_tdata);
          if (fill_count + CNT_W'(1) >= frame_length) begin
            state_next = FR_CRC;
          end
        end
        FR_CRC: begin
          wr_bank_next = wr_bank + BANK_W'(1);
          state_next   = FR_HUNT;
        end
        default: begin
          state_next = FR_HUNT;
        end
      endcase
    end
  end

  // bank busy tracking
  always_comb begin
    busy_next = busy;
    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (push) begin
      busy_next[wr_bank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= FR_HUNT;
      frame_length <= '0;
      fill_count   <= '0;
      running_crc  <= CRC_INIT;
      wr_bank      <= '0;
      busy         <= '0;
    end else begin
      state        <= state_next;
      frame_length <= frame_length_next;
      fill_count   <= fill_count_next;
      running_crc  <= running_crc_next;
      wr_bank      <= wr_bank_next;
      busy         <= busy_next;
    end
  end

  always_ff @(posedge clk) begin
    signal_id <= signal_id_next;
  end

endmodule

`default_nettype wire

// File: sv/crcfr_fifo.sv
`default_nettype none

module crcfr_fifo (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  crcfr_pkg::cmd_t push_cmd,
  input  wire logic       pop,
  output crcfr_pkg::cmd_t head,
  output logic            empty,
  output logic            full
);
  import crcfr_pkg::*;

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head  = entry[rd_ptr];
  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// File: sv/crcfr_back.sv
`default_nettype none

module crcfr_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  crcfr_pkg::cmd_t                    head,
  input  wire logic                          empty,
  output logic                               pop,
  output logic                               ram_re,
  output logic      [crcfr_pkg::RAM_AW-1:0]  ram_raddr,
  input  wire logic [7:0]                    ram_rdata,
  output crcfr_pkg::rel_t                    rel,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_status,
  output logic      [7:0]                    out_sig,
  output logic                               out_has,
  output logic      [7:0]                    out_pb,
  output logic      [crcfr_pkg::IDX_W-1:0]   out_idx,
  output logic      [crcfr_pkg::CNT_W-1:0]   out_cnt,
  output logic                               out_last
);
  import crcfr_pkg::*;

  back_state_t      state, state_next;
  cmd_t             cur;
  logic [IDX_W-1:0] idx, idx_next;
  logic             out_free;
  logic             load_one;
  logic             load_byte;
  logic             byte_last;

  assign out_free  = !out_valid || out_ready;
  assign pop       = (state == BK_IDLE) && !empty;
  assign ram_re    = (state == BK_RD);
  assign ram_raddr = {cur.bank, idx};
  assign byte_last = ({1'b0, idx} + CNT_W'(1)) == cur.count;
  assign load_one  = (state == BK_ONE) && out_free;
  assign load_byte = (state == BK_LD) && out_free;

  assign rel.valid = load_one || (load_byte && byte_last);
  assign rel.bank  = cur.bank;

  // result sequencer
  always_comb begin
    state_next = state;
    idx_next   = idx;
    unique case (state)
      BK_IDLE: begin
        if (!empty) begin
          idx_next = '0;
          if ((head.status == STATUS_CRC_ERR) || (head.count == '0)) begin
            state_next = BK_ONE;
          end else begin
            state_next = BK_RD;
          end
        end
      end
      BK_ONE: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      BK_RD: begin
        state_next = BK_LD;
      end
      BK_LD: begin
        if (out_free) begin
          if (byte_last) begin
            state_next = BK_IDLE;
          end else begin
            idx_next   = idx + IDX_W'(1);
            state_next = BK_RD;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // current frame
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_one || load_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_one) begin
      out_status <= cur.status;
      out_sig    <= cur.signal_id;
      out_has    <= 1'b0;
      out_pb     <= 8'd0;
      out_idx    <= '0;
      out_cnt    <= cur.count;
      out_last   <= 1'b1;
    end else if (load_byte) begin
      out_status <= STATUS_OK;
      out_sig    <= cur.signal_id;
      out_has    <= 1'b1;
      out_pb     <= ram_rdata;
      out_idx    <= idx;
      out_cnt    <= cur.count;
      out_last   <= byte_last;
    end
  end

endmodule

`default_nettype wire

// File: sv/crc8_frame_receiver.sv
// after the crc byte, results go via the frame queue, back sequencer and output register
// one received byte per cycle while s_tready is high; payload results each take a read
//   state and a load into the output register, as the two-bank buffer read is registered
// the input stalls only in a frame body whose buffer bank still holds a frame to be sent
// reset: rst is synchronous; it clears control state and sets start_byte to 0xaa,
//   buffer contents are left as they are and no clearing pass is run
`default_nettype none

module crc8_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata,   // [7:0] signal_id, [15:8] payload_byte,
                                      // [21:16] byte_index, [28:22] payload_count
  output logic      [1:0]  m_tuser,   // [0] status, [1] has_byte
  output logic             m_tlast
);
  import crcfr_pkg::*;

  logic                  ram_we;
  logic [RAM_AW-1:0]     ram_waddr;
  logic [7:0]            ram_wdata;
  logic                  ram_re;
  logic [RAM_AW-1:0]     ram_raddr;
  logic [7:0]            ram_rdata;
  logic                  push;
  cmd_t                  push_cmd;
  logic                  pop;
  cmd_t                  head;
  logic                  fifo_empty;
  logic                  fifo_full;
  rel_t                  rel;
  logic [NUM_BANKS-1:0]  busy;
  logic                  out_status;
  logic [7:0]            out_sig;
  logic                  out_has;
  logic [7:0]            out_pb;
  logic [IDX_W-1:0]      out_idx;
  logic [CNT_W-1:0]      out_cnt;

  // byte intake and frame checking
  crcfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .push      (push),
    .push_cmd  (push_cmd),
    .rel       (rel),
    .busy      (busy)
  );

  // two-bank payload buffer
  crcfr_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // finished frames waiting for the back end
  crcfr_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (fifo_empty),
    .full     (fifo_full)
  );

  // result generation
  crcfr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (fifo_empty),
    .pop        (pop),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .rel        (rel),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (out_status),
    .out_sig    (out_sig),
    .out_has    (out_has),
    .out_pb     (out_pb),
    .out_idx    (out_idx),
    .out_cnt    (out_cnt),
    .out_last   (m_tlast)
  );

  // output packing
  assign m_tdata = {3'b000, out_cnt, out_idx, out_pb, out_sig};
  assign m_tuser = {out_has, out_status};

  // a finished frame always finds room in the queue
  assert property (@(posedge clk) disable iff (rst) push |-> !fifo_full)
    else $error("frame queue overflow");

  // never write into a bank that is still being drained
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !busy[ram_waddr[RAM_AW-1]])
    else $error("write into busy buffer bank");

  // a crc error is a single result without a byte
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tlast && !m_tuser[1]))
    else $error("crc error result malformed");

  // a bank is released only by the back end while it is marked busy
  assert property (@(posedge clk) disable iff (rst)
    rel.valid |-> busy[rel.bank])
    else $error("release of idle buffer bank");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import crcfr_pkg::*;

  localparam int STORE_DEPTH  = MAX_PAYLOAD_BYTES + 1;
  localparam int SETTLE_CYCLES = 16;    // settle time after the result queue drains
  localparam int STALL_LIMIT  = 4000;   // cycles with no transaction on either side
  localparam int HOLD_STRETCH = 300;    // long receiver hold-off
  localparam int MAX_REPORTS  = 10;

  typedef logic [7:0] byte_q_t[$];

  // one deframed result as it leaves the block
  typedef struct packed {
    logic       status;
    logic [7:0] sig_id;
    logic       has_byte;
    logic [7:0] pay_byte;
    logic [5:0] idx;
    logic [6:0] count;
    logic       last;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'h00;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  // predictor state
  front_state_t rx_state = FR_HUNT;
  logic [7:0]   start_sel = START_RESET;
  logic [6:0]   frame_len = '0;
  logic [6:0]   stored_cnt = '0;
  logic [7:0]   crc_acc = CRC_INIT;
  logic [7:0]   frame_bytes [STORE_DEPTH];

  frame_result_t pending_results[$];

  int  sent_items = 0;
  int  mismatch_cnt = 0;
  int  hold_cycles = 0;
  int  stall_cnt = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;

  crc8_frame_receiver dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always #5 clk = ~clk;

  // bit-serial crc-8, msb first
  function automatic logic [7:0] crc8_shift(input logic [7:0] acc, input logic [7:0] din);
    logic [7:0] r;
    logic       fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ din[i];
      r = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  // advance the deframer by one received byte, queue any results it causes
  task automatic deframe_byte(input logic [7:0] b);
    logic [6:0]    cnt;
    logic [7:0]    sig;
    frame_result_t r;
    case (rx_state)
      FR_HUNT: begin
        if (b == start_sel) begin
          stored_cnt = '0;
          rx_state = FR_LEN;
        end
      end
      FR_LEN: begin
        // bad length drops the frame, and the byte is not rechecked as a start
        if (b == 8'h00 || int'(b) > MAX_PAYLOAD_BYTES + 1) begin
          rx_state = FR_HUNT;
        end else begin
          frame_len = b[6:0];
          stored_cnt = '0;
          crc_acc = CRC_INIT;
          rx_state = FR_BODY;
        end
      end
      FR_BODY: begin
        if (int'(stored_cnt) < STORE_DEPTH) begin
          frame_bytes[stored_cnt] = b;
          stored_cnt++;
        end
        crc_acc = crc8_shift(crc_acc, b);
        if (stored_cnt >= frame_len) rx_state = FR_CRC;
      end
      default: begin
        cnt = (stored_cnt > 0) ? stored_cnt - 7'd1 : 7'd0;
        sig = (stored_cnt > 0) ? frame_bytes[0] : 8'h00;
        rx_state = FR_HUNT;
        if (b != crc_acc) begin
          r = '{STATUS_CRC_ERR, sig, 1'b0, 8'h00, 6'd0, cnt, 1'b1};
          pending_results.push_back(r);
        end else if (cnt == 0) begin
          r = '{STATUS_OK, sig, 1'b0, 8'h00, 6'd0, 7'd0, 1'b1};
          pending_results.push_back(r);
        end else begin
          for (int i = 0; i < int'(cnt); i++) begin
            r = '{STATUS_OK, sig, 1'b1, frame_bytes[i + 1], 6'(i), cnt,
                  (i + 1 == int'(cnt))};
            pending_results.push_back(r);
          end
        end
      end
    endcase
  endtask

  // offer one byte after a random gap, wait for the transaction
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_items++;
    deframe_byte(b);
  endtask

  // start, length, body (signal id + payload), crc
  task automatic send_frame(input byte_q_t body, input bit bad_crc);
    logic [7:0] crc;
    crc = CRC_INIT;
    foreach (body[i]) crc = crc8_shift(crc, body[i]);
    if (bad_crc) crc ^= 8'($urandom_range(1, 255));
    send_byte(start_sel);
    send_byte(8'(body.size()));
    foreach (body[i]) send_byte(body[i]);
    send_byte(crc);
  endtask

  function automatic byte_q_t random_body(input int npay);
    byte_q_t q;
    for (int i = 0; i <= npay; i++) q.push_back(8'($urandom_range(0, 255)));
    return q;
  endfunction

  // mostly short payloads, now and then a long one
  function automatic int pick_payload_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 90) return $urandom_range(0, 8);
    if (r < 98) return $urandom_range(9, 20);
    return $urandom_range(MAX_PAYLOAD_BYTES - 1, MAX_PAYLOAD_BYTES);
  endfunction

  // feed bytes until the deframer is back to hunting
  task automatic resync();
    while (rx_state != FR_HUNT)
      send_byte(rx_state == FR_LEN ? 8'h00 : 8'($urandom_range(0, 255)));
  endtask

  // stop sending and wait for every queued result plus settle time
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_start(input logic [7:0] v);
    resync();
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    start_sel = v;
  endtask

  // one random frame, bad-length attempt or burst of line noise
  task automatic send_random_unit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      resync();
    end else if (r < 14) begin
      send_byte(start_sel);
      send_byte(($urandom_range(0, 1) == 0) ? 8'h00
                : 8'($urandom_range(MAX_PAYLOAD_BYTES + 2, 255)));
    end else begin
      send_frame(random_body(pick_payload_len()), ($urandom_range(0, 4) == 0));
    end
  endtask

  task automatic test_directed();
    // noise while hunting
    send_byte(8'h00);
    send_byte(8'hFF);
    // empty payload, good crc then bad crc
    send_frame('{8'h00}, 1'b0);
    send_frame('{8'hFF}, 1'b1);
    // zero length and one past the maximum
    send_byte(start_sel);
    send_byte(8'h00);
    send_byte(start_sel);
    send_byte(8'(MAX_PAYLOAD_BYTES + 2));
    // start byte as a bad length is not a new start
    send_byte(start_sel);
    send_byte(start_sel);
    // start byte inside the payload is plain data
    send_frame('{8'h5A, 8'h00, 8'hAA, 8'hFF}, 1'b0);
    drain_results();
  endtask

  task automatic test_start_byte_settings();
    logic [7:0] vals [4];
    vals = '{8'h00, 8'hFF, 8'($urandom_range(1, 254)), START_RESET};
    foreach (vals[k]) begin
      write_start(vals[k]);
      send_byte(8'h00);
      send_byte(8'hFF);
      resync();
      repeat (2) send_random_unit();
    end
    drain_results();
  endtask

  task automatic test_random_traffic();
    int first;
    int next_cfg;
    first = sent_items;
    next_cfg = first + 70;
    send_frame(random_body(MAX_PAYLOAD_BYTES), 1'b0);
    while (sent_items - first < 90) begin
      send_random_unit();
      if (sent_items >= next_cfg) begin
        write_start(8'($urandom_range(0, 255)));
        next_cfg = sent_items + 70;
      end
    end
    write_start(START_RESET);
  endtask

  // receiver holds off while the sender keeps going, both banks fill
  task automatic test_output_holdoff();
    hold_cycles = HOLD_STRETCH;
    repeat (5) send_frame(random_body($urandom_range(4, 8)), 1'b0);
    send_frame(random_body(3), 1'b1);
    drain_results();
  endtask

  // back to back on both sides
  task automatic test_full_rate();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (4) send_random_unit();
    resync();
    drain_results();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // receiver ready with random gaps and the occasional long hold
  initial begin : result_ready
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      gap = rx_idle_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready) && hold_cycles == 0);
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin : result_check
    frame_result_t want;
    frame_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tuser[0], m_tdata[7:0], m_tuser[1], m_tdata[15:8], m_tdata[21:16],
              m_tdata[28:22], m_tlast};
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected result: st=%0d sig=%h has=%0d pb=%h idx=%0d cnt=%0d last=%0d",
                   got.status, got.sig_id, got.has_byte, got.pay_byte, got.idx,
                   got.count, got.last);
      end else begin
        want = pending_results.pop_front();
        if (got !== want || m_tdata[31:29] !== 3'b000) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS) begin
            $display("mismatch exp: st=%0d sig=%h has=%0d pb=%h idx=%0d cnt=%0d last=%0d",
                     want.status, want.sig_id, want.has_byte, want.pay_byte, want.idx,
                     want.count, want.last);
            $display({"         got: st=%0d sig=%h has=%0d pb=%h idx=%0d cnt=%0d",
                      " last=%0d pad=%b"},
                     got.status, got.sig_id, got.has_byte, got.pay_byte, got.idx,
                     got.count, got.last, m_tdata[31:29]);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt + 1 >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_start_byte_settings();
    test_random_traffic();
    test_output_holdoff();
    test_full_rate();
    drain_results();
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
